// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL. Each macro expects clk in scope; WGM_ASSERT also expects arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define WGM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define WGM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/wgm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

	localparam int MAX_PATTERN_DEF = 64;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_BEGIN  = 2'd2;
	localparam logic [1:0] MODE_TEXT   = 2'd3;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE  = 8'h3F;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] symbol;
	} req_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} rsp_t;

	// Operation token that walks down the cell chain, one cell per cycle while the chain is not held.
	typedef struct packed {
		logic       valid;
		logic [1:0] mode;
		logic [7:0] symbol;
		logic       diag;    // previous row bit of the cell to the left
		logic       left;    // new row bit of the cell to the left
		logic       res;     // new row bit of the last occupied cell so far
		logic       placed;  // an append has found its cell
	} tok_t;

endpackage

`default_nettype wire

// ----- rtl/core/wgm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wgm_cell (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            en,
	input  wgm_pkg::tok_t  tok_in,
	output wgm_pkg::tok_t  tok_out
);

	logic [7:0]    pat_q;
	logic          used_q;
	logic          bit_q;
	wgm_pkg::tok_t tok_q;

	wgm_pkg::tok_t tok_nxt;
	logic          used_nxt;
	logic          bit_nxt;
	logic          pat_load;
	logic          cur;
	logic          hit;
	logic          star;

	always_comb begin
		tok_nxt  = tok_in;
		used_nxt = used_q;
		bit_nxt  = bit_q;
		pat_load = 1'b0;
		cur      = 1'b0;
		hit      = (pat_q == tok_in.symbol) || (pat_q == wgm_pkg::ANY_BYTE);
		star     = (pat_q == wgm_pkg::STAR_BYTE);
		case (tok_in.mode)
			wgm_pkg::MODE_CLEAR: begin
				used_nxt = 1'b0;
				bit_nxt  = 1'b0;
			end
			wgm_pkg::MODE_APPEND: begin
				if (!used_q && !tok_in.placed) begin
					used_nxt       = 1'b1;
					bit_nxt        = 1'b0;
					pat_load       = 1'b1;
					tok_nxt.placed = 1'b1;
				end
			end
			wgm_pkg::MODE_BEGIN: begin
				// Empty text: only a leading run of stars matches.
				cur          = used_q && tok_in.left && star;
				bit_nxt      = cur;
				tok_nxt.left = cur;
				if (used_q) begin
					tok_nxt.res = cur;
				end
			end
			wgm_pkg::MODE_TEXT: begin
				// An exact or any-byte match wins over the star rule.
				if (hit) begin
					cur = tok_in.diag;
				end else if (star) begin
					cur = bit_q || tok_in.left;
				end
				cur          = cur && used_q;
				bit_nxt      = cur;
				tok_nxt.diag = bit_q;
				tok_nxt.left = cur;
				if (used_q) begin
					tok_nxt.res = cur;
				end
			end
			default: begin
				tok_nxt = tok_in;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			bit_q  <= 1'b0;
			tok_q  <= '0;
		end else if (en) begin
			tok_q <= tok_nxt;
			if (tok_in.valid) begin
				used_q <= used_nxt;
				bit_q  <= bit_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && tok_in.valid && pat_load) begin
			pat_q <= tok_in.symbol;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ----- rtl/core/wildcard_glob_matcher.sv -----
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   wgm_pkg::req_t (mode, symbol)
// rsp       out        rsp_valid/rsp_ready   wgm_pkg::rsp_t (matched, overflow)
//
// One item is taken per cycle while req_ready is high. Every item walks the row of
// MAX_PATTERN cells, one cell per cycle while the chain is not held; a begin or text
// item leaving the last cell is registered into the output register, raising rsp_valid.
// Items overlap in the cell chain, so the rate is one item per cycle when nothing is held.
// Reset clears all control state at once; pattern bytes are not reset.
// The whole chain holds only while a result sits at the end of the row and the
// output register is full and not taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wildcard_glob_matcher #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_ready,
	input  wgm_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_ready,
	output wgm_pkg::rsp_t  rsp
);

	// Token chain: chain[0] is the incoming item, chain[j+1] leaves cell j.
	wgm_pkg::tok_t              chain [0:MAX_PATTERN];
	wgm_pkg::tok_t              head_tok;
	wgm_pkg::tok_t              tail_tok;
	logic                       chain_en;
	logic                       tail_blocked;
	logic                       tail_result;

	logic                       at_start_q;
	logic                       ovf_q;
	logic                       rsp_valid_q;
	wgm_pkg::rsp_t              rsp_q;

	// Operations enter the row in transfer order and every cell sees them in that
	// same order, so the row behaves as if each item were applied all at once.
	assign tail_tok     = chain[MAX_PATTERN];
	assign tail_result  = tail_tok.valid &&
		(tail_tok.mode inside {wgm_pkg::MODE_BEGIN, wgm_pkg::MODE_TEXT});
	assign tail_blocked = tail_result && rsp_valid_q && !rsp_ready;
	assign chain_en     = !tail_blocked;
	assign req_ready    = chain_en;

	// The head token starts the row recurrence. A begin enters with an implicit
	// match to its left so that a leading run of stars matches the empty text.
	// The result bit starts as the empty-pattern answer.
	always_comb begin
		head_tok.valid  = req_valid;
		head_tok.mode   = req.mode;
		head_tok.symbol = req.symbol;
		head_tok.diag   = at_start_q;
		head_tok.left   = (req.mode == wgm_pkg::MODE_BEGIN);
		head_tok.res    = (req.mode == wgm_pkg::MODE_BEGIN);
		head_tok.placed = 1'b0;
	end

	assign chain[0] = head_tok;

	// The text-start flag only matters to the first cell, so it lives at the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
		end else if (req_valid && req_ready) begin
			case (req.mode)
				wgm_pkg::MODE_CLEAR: at_start_q <= 1'b1;
				wgm_pkg::MODE_BEGIN: at_start_q <= 1'b1;
				wgm_pkg::MODE_TEXT:  at_start_q <= 1'b0;
				default:             at_start_q <= at_start_q;
			endcase
		end
	end

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		wgm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (chain_en),
			.tok_in  (chain[j]),
			.tok_out (chain[j+1])
		);
	end

	// The sticky overflow flag is kept at the tail, where tokens leave in order:
	// an append that no free cell took was dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (chain_en) begin
			if (tail_tok.valid) begin
				case (tail_tok.mode)
					wgm_pkg::MODE_CLEAR: ovf_q <= 1'b0;
					wgm_pkg::MODE_APPEND: begin
						if (!tail_tok.placed) begin
							ovf_q <= 1'b1;
						end
					end
					default: ovf_q <= ovf_q;
				endcase
			end
			if (tail_result) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain_en && tail_result) begin
			rsp_q.matched  <= tail_tok.res;
			rsp_q.overflow <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A result that is offered and not taken stays offered and unchanged.
	`WGM_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)), "result changed while waiting")

	// The overflow flag is only raised by a dropped append reaching the tail.
	`WGM_ASSERT(a_ovf_cause, ($rose(ovf_q) |-> $past(tail_tok.valid && tail_tok.mode == wgm_pkg::MODE_APPEND && !tail_tok.placed)), "overflow set without a dropped append")

	// A blocked result at the tail is held in place until the output register frees.
	`WGM_ASSERT(a_tail_hold, (tail_blocked |=> $stable(tail_tok)), "tail token moved while blocked")

endmodule

`default_nettype wire
